[hw/rtl/pru_pkg.sv]
// ----------------------------------------------------------------------------
// pru_pkg
// Shared widths, register indexes and controller/datapath interface structs
// for the pixel replication upscaler.
// ----------------------------------------------------------------------------
package pru_pkg;

  // field widths
  localparam int PIXEL_W    = 24;
  localparam int ADDR_W     = 26;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 56;

  // configuration register widths
  localparam int ROWS_CFG_W  = 11;
  localparam int COLS_CFG_W  = 11;
  localparam int SCALE_CFG_W = 4;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_IDX_W   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // latch pixel and clamped config
    logic stride;   // first multiply stage
    logic base;     // second multiply stage, start of copies
    logic advance;  // current copy taken downstream
  } pru_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last_copy;
  } pru_status_t;

endpackage

[hw/rtl/pixel_replication_upscaler.sv]
// ----------------------------------------------------------------------------
// pixel_replication_upscaler
// Nearest-neighbor integer upscaler: each source pixel goes out as
// scale x scale copies, each with its linear address in the enlarged frame.
//
//   channel  direction  ports                          word
//   in       slave      in_tvalid/in_tready/in_tdata   one source pixel
//   out      master     out_tvalid/out_tready/out_*    one copy with address
//   cfg      slave      cfg_valid/cfg_ready/cfg_*      one register write
//
// A pixel is taken in the idle state, then runs through the address setup
// states STRIDE and BASE and the copy walk before the block is idle again.
// The setup states are the address multipliers (cols*s, row*s, col*s,
// then row*s*stride); after that the walker hands out one copy per cycle
// while the output is not stalled. Output stalls hold the current copy;
// no new pixel is taken until the last copy of the current one has gone.
// Reset sets the config registers to one and the source position to zero.
// ----------------------------------------------------------------------------
module pixel_replication_upscaler #(
  parameter int MAX_ROWS  = 1024,
  parameter int MAX_COLS  = 1024,
  parameter int MAX_SCALE = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // pixel input
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pru_pkg::IN_TDATA_W-1:0]     in_tdata,   // [23:0] pixel_value
  // copy output
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pru_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [25:0] out_address,
                                                         // [49:26] out_pixel
  output logic                               out_tlast,  // run_last
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pru_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pru_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pru_pkg::*;

  pru_cmd_t           cmd;
  pru_status_t        status;
  logic [ADDR_W-1:0]  out_address;
  logic [PIXEL_W-1:0] out_pixel;

  // config channel never stalls
  assign cfg_ready = 1'b1;

  // controller
  pru_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // datapath
  pru_datapath #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .MAX_SCALE (MAX_SCALE)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_in    (in_tdata[PIXEL_W-1:0]),
    .cmd         (cmd),
    .status      (status),
    .out_address (out_address),
    .out_pixel   (out_pixel)
  );

  // output word packing
  assign out_tdata = {(OUT_TDATA_W - ADDR_W - PIXEL_W)'(0), out_pixel, out_address};
  assign out_tlast = status.last_copy;

endmodule

[hw/rtl/pru_ctrl.sv]
// ----------------------------------------------------------------------------
// pru_ctrl
// Controller state machine: takes one pixel, steps the datapath through its
// address setup states (stride, base), then hands out copies until the last one.
// ----------------------------------------------------------------------------
module pru_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  pru_pkg::pru_status_t status,
  output pru_pkg::pru_cmd_t    cmd
);
  import pru_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_STRIDE = 4'b0010,
    ST_BASE   = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // handshake outputs
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_EMIT);

  // commands to the datapath
  always_comb begin
    cmd.load    = in_tvalid & in_tready;
    cmd.stride  = (state_r == ST_STRIDE);
    cmd.base    = (state_r == ST_BASE);
    cmd.advance = out_tvalid & out_tready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_STRIDE;
      end
      ST_STRIDE: state_nxt = ST_BASE;
      ST_BASE:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_tready && status.last_copy) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/pru_datapath.sv]
// ----------------------------------------------------------------------------
// pru_datapath
// Config registers, source position counters, address multipliers and the
// copy address walker for the pixel replication upscaler.
// ----------------------------------------------------------------------------
module pru_datapath #(
  parameter int MAX_ROWS  = 1024,
  parameter int MAX_COLS  = 1024,
  parameter int MAX_SCALE = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pru_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pru_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [pru_pkg::PIXEL_W-1:0]      pixel_in,
  input  pru_pkg::pru_cmd_t                cmd,
  output pru_pkg::pru_status_t             status,
  output logic [pru_pkg::ADDR_W-1:0]       out_address,
  output logic [pru_pkg::PIXEL_W-1:0]      out_pixel
);
  import pru_pkg::*;

  // counter and clamped-value widths
  localparam int RW  = (MAX_ROWS  > 1) ? $clog2(MAX_ROWS)  : 1;
  localparam int CW  = (MAX_COLS  > 1) ? $clog2(MAX_COLS)  : 1;
  localparam int IW  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int RNW = $clog2(MAX_ROWS + 1);
  localparam int CNW = $clog2(MAX_COLS + 1);
  localparam int SW  = $clog2(MAX_SCALE + 1);
  localparam int STW = CNW + SW;
  localparam int RSW = RW + SW;
  localparam int CSW = CW + SW;

  // configuration registers
  logic [ROWS_CFG_W-1:0]  rows_cfg_r;
  logic [COLS_CFG_W-1:0]  cols_cfg_r;
  logic [SCALE_CFG_W-1:0] scale_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r  <= ROWS_CFG_W'(1);
      cols_cfg_r  <= COLS_CFG_W'(1);
      scale_cfg_r <= SCALE_CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_ROWS:   rows_cfg_r  <= cfg_data[ROWS_CFG_W-1:0];
        REG_FRAME_COLS:   cols_cfg_r  <= cfg_data[COLS_CFG_W-1:0];
        REG_SCALE_FACTOR: scale_cfg_r <= cfg_data[SCALE_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // zero reads as one, oversize saturates
  logic [31:0] rows_lim;
  logic [31:0] cols_lim;
  logic [31:0] scale_lim;

  always_comb begin
    rows_lim  = (rows_cfg_r == '0) ? 32'd1 :
                (32'(rows_cfg_r) > MAX_ROWS) ? 32'(MAX_ROWS) : 32'(rows_cfg_r);
    cols_lim  = (cols_cfg_r == '0) ? 32'd1 :
                (32'(cols_cfg_r) > MAX_COLS) ? 32'(MAX_COLS) : 32'(cols_cfg_r);
    scale_lim = (scale_cfg_r == '0) ? 32'd1 :
                (32'(scale_cfg_r) > MAX_SCALE) ? 32'(MAX_SCALE) : 32'(scale_cfg_r);
  end

  // per-item operands
  logic [PIXEL_W-1:0] pix_r;
  logic [RNW-1:0]     rows_r;
  logic [CNW-1:0]     cols_r;
  logic [SW-1:0]      scale_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_r   <= pixel_in;
      rows_r  <= RNW'(rows_lim);
      cols_r  <= CNW'(cols_lim);
      scale_r <= SW'(scale_lim);
    end
  end

  // source position
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;

  // address setup products
  logic [STW-1:0]    stride_r;
  logic [RSW-1:0]    row_s_r;
  logic [CSW-1:0]    col_s_r;
  logic [ADDR_W-1:0] base_sum;

  always_ff @(posedge clk) begin
    if (cmd.stride) begin
      stride_r <= STW'(cols_r) * STW'(scale_r);
      row_s_r  <= RSW'(row_r) * RSW'(scale_r);
      col_s_r  <= CSW'(col_r) * CSW'(scale_r);
    end
  end

  assign base_sum = ADDR_W'(row_s_r) * ADDR_W'(stride_r) + ADDR_W'(col_s_r);

  // copy walker: i is the vertical repeat, j the horizontal one
  logic [IW-1:0]     i_r;
  logic [IW-1:0]     j_r;
  logic [ADDR_W-1:0] line_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] line_next;
  logic              j_end;
  logic              last_copy;

  assign line_next = line_r + ADDR_W'(stride_r);
  assign j_end     = (SW'(j_r) == scale_r - SW'(1));
  assign last_copy = j_end && (SW'(i_r) == scale_r - SW'(1));

  always_ff @(posedge clk) begin
    if (cmd.base) begin
      line_r <= base_sum;
      addr_r <= base_sum;
      i_r    <= '0;
      j_r    <= '0;
    end else if (cmd.advance && !last_copy) begin
      if (j_end) begin
        j_r    <= '0;
        i_r    <= i_r + IW'(1);
        line_r <= line_next;
        addr_r <= line_next;
      end else begin
        j_r    <= j_r + IW'(1);
        addr_r <= addr_r + ADDR_W'(1);
      end
    end
  end

  // position step after the last copy of a pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.advance && last_copy) begin
      if (CNW'(col_r) + CNW'(1) >= cols_r) begin
        col_r <= '0;
        if (RNW'(row_r) + RNW'(1) >= rows_r) begin
          row_r <= '0;
        end else begin
          row_r <= row_r + RW'(1);
        end
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  assign status.last_copy = last_copy;
  assign out_address      = addr_r;
  assign out_pixel        = pix_r;

endmodule

[hw/rtl/pru_checker.sv]
// ----------------------------------------------------------------------------
// pru_checker
// Port-level checks for the pixel replication upscaler, bound to the top.
// ----------------------------------------------------------------------------
module pru_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [pru_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                             out_tlast
);
  import pru_pkg::*;

  // a stalled copy holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output word changed");

  // one pixel at a time: no input taken while copies are out
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while copies pending");

  // address setup follows an accepted pixel
  a_setup_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid && !in_tready)
    else $error("no setup cycle after pixel accept");

  // last copy taken ends the run
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid && in_tready)
    else $error("run did not end after last copy");

endmodule

bind pixel_replication_upscaler pru_checker u_pru_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pixel_replication_upscaler. A short table of
// directed register writes and pixels opens the run, followed by a short
// row sweep and random frames under random register settings. Every pixel
// taken is expanded by a local copy generator into its scale x scale copies,
// and each copy leaving the block is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import pru_pkg::*;

  localparam int unsigned MAX_ROWS      = 1024;
  localparam int unsigned MAX_COLS      = 1024;
  localparam int unsigned MAX_SCALE     = 8;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          RANDOM_PIXELS = 66;
  localparam int          DEEP_PIXELS   = 16;
  localparam int          PRINT_CAP     = 40;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [PIXEL_W-1:0] pixel;
    logic               last;
  } copy_t;

  typedef enum logic {STEP_CFG, STEP_PIXEL} step_kind_e;

  typedef struct {
    step_kind_e            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    logic [PIXEL_W-1:0]    pix;
    bit                    typed;
    logic [ADDR_W-1:0]     t_addr;
    logic                  t_last;
  } step_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [23:0] pixel_value
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [25:0] out_address, [49:26] out_pixel
  logic                   out_tlast;       // run_last
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // register mirror and source position
  logic [ROWS_CFG_W-1:0]  rows_reg;
  logic [COLS_CFG_W-1:0]  cols_reg;
  logic [SCALE_CFG_W-1:0] scale_reg;
  logic [9:0]             src_row;
  logic [9:0]             src_col;

  copy_t expected_copies[$];
  copy_t fresh_copies[$];
  copy_t pinned_copy;
  bit    pinned_valid = 1'b0;
  bit    calm = 1'b0;
  int    pixels_accepted = 0;
  int    reg_writes_accepted = 0;
  int    copies_seen = 0;
  int    mismatch_count = 0;
  int    cycle_count = 0;

  step_t directed_steps[$] = '{
    // reset settings: one copy at address zero, frame wraps every pixel
    '{STEP_PIXEL, REG_FRAME_ROWS,   11'd0,     24'hFFFFFF, 1'b1, 26'd0, 1'b1},
    '{STEP_PIXEL, REG_FRAME_ROWS,   11'd0,     24'h000000, 1'b1, 26'd0, 1'b1},
    // zero in any register acts as one
    '{STEP_CFG,   REG_FRAME_ROWS,   11'd0,     24'h0,      1'b0, 26'd0, 1'b0},
    '{STEP_CFG,   REG_FRAME_COLS,   11'd0,     24'h0,      1'b0, 26'd0, 1'b0},
    '{STEP_CFG,   REG_SCALE_FACTOR, 11'd0,     24'h0,      1'b0, 26'd0, 1'b0},
    '{STEP_PIXEL, REG_FRAME_ROWS,   11'd0,     24'h5A5A5A, 1'b1, 26'd0, 1'b1},
    // full 2x3 frame at scale eight, then one past the wrap
    '{STEP_CFG,   REG_FRAME_ROWS,   11'd2,     24'h0,      1'b0, 26'd0, 1'b0},
    '{STEP_CFG,   REG_FRAME_COLS,   11'd3,     24'h0,      1'b0, 26'd0, 1'b0},
    '{STEP_CFG,   REG_SCALE_FACTOR, 11'd8,     24'h0,      1'b0, 26'd0, 1'b0},
    '{STEP_PIXEL, REG_FRAME_ROWS,   11'd0,     24'h800000, 1'b0, 26'd0, 1'b0},
    '{STEP_PIXEL, REG_FRAME_ROWS,   11'd0,     24'h000001, 1'b0, 26'd0, 1'b0},
    '{STEP_PIXEL, REG_FRAME_ROWS,   11'd0,     24'h7FFFFF, 1'b0, 26'd0, 1'b0},
    '{STEP_PIXEL, REG_FRAME_ROWS,   11'd0,     24'hFFFFFE, 1'b0, 26'd0, 1'b0},
    '{STEP_PIXEL, REG_FRAME_ROWS,   11'd0,     24'h123456, 1'b0, 26'd0, 1'b0},
    '{STEP_PIXEL, REG_FRAME_ROWS,   11'd0,     24'hABCDEF, 1'b0, 26'd0, 1'b0},
    '{STEP_PIXEL, REG_FRAME_ROWS,   11'd0,     24'hC3C3C3, 1'b0, 26'd0, 1'b0},
    // values above range saturate, scale keeps only its low nibble
    '{STEP_CFG,   REG_FRAME_ROWS,   11'h7FF,   24'h0,      1'b0, 26'd0, 1'b0},
    '{STEP_CFG,   REG_FRAME_COLS,   11'h7FF,   24'h0,      1'b0, 26'd0, 1'b0},
    '{STEP_CFG,   REG_SCALE_FACTOR, 11'h7FF,   24'h0,      1'b0, 26'd0, 1'b0},
    '{STEP_PIXEL, REG_FRAME_ROWS,   11'd0,     24'h00FF00, 1'b0, 26'd0, 1'b0},
    '{STEP_PIXEL, REG_FRAME_ROWS,   11'd0,     24'hFF00FF, 1'b0, 26'd0, 1'b0},
    // write to the spare index changes nothing
    '{STEP_CFG,   REG_SPARE,        11'h7FF,   24'h0,      1'b0, 26'd0, 1'b0},
    '{STEP_PIXEL, REG_FRAME_ROWS,   11'd0,     24'h0F0F0F, 1'b0, 26'd0, 1'b0},
    // column count shrinks below the position mid-frame: column 4 wraps
    '{STEP_CFG,   REG_FRAME_COLS,   11'd2,     24'h0,      1'b0, 26'd0, 1'b0},
    '{STEP_CFG,   REG_SCALE_FACTOR, 11'h7F1,   24'h0,      1'b0, 26'd0, 1'b0},
    '{STEP_PIXEL, REG_FRAME_ROWS,   11'd0,     24'hF0F0F0, 1'b1, 26'd4, 1'b1},
    '{STEP_PIXEL, REG_FRAME_ROWS,   11'd0,     24'h333333, 1'b1, 26'd2, 1'b1},
    // row count shrinks below the position mid-frame
    '{STEP_CFG,   REG_FRAME_ROWS,   11'd1,     24'h0,      1'b0, 26'd0, 1'b0},
    '{STEP_CFG,   REG_SCALE_FACTOR, 11'd5,     24'h0,      1'b0, 26'd0, 1'b0},
    '{STEP_PIXEL, REG_FRAME_ROWS,   11'd0,     24'h999999, 1'b0, 26'd0, 1'b0},
    '{STEP_PIXEL, REG_FRAME_ROWS,   11'd0,     24'h666666, 1'b0, 26'd0, 1'b0}
  };

  pixel_replication_upscaler #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .MAX_SCALE (MAX_SCALE)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned clamp_reg(input logic [10:0] v,
                                                input longint unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 24);
  endfunction

  function automatic logic [PIXEL_W-1:0] random_pixel();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return PIXEL_W'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_dim();
    case ($urandom_range(9))
      0: return '0;
      1: return CFG_DATA_W'($urandom_range(1000, 1024));
      2: return CFG_DATA_W'($urandom_range(1025, 2047));
      default: return CFG_DATA_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] wanted,
                                 input logic [63:0] got);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch in %s at copy %0d: expected 0x%0h, got 0x%0h",
               what, copies_seen, wanted, got);
    mismatch_count++;
  endtask

  // expand one pixel into its copies and step the source position
  task automatic replicate_pixel(input logic [PIXEL_W-1:0] pix);
    longint unsigned n_rows, n_cols, n_scale, row_v, col_v, origin, i, j;
    n_rows  = clamp_reg(rows_reg, MAX_ROWS);
    n_cols  = clamp_reg(cols_reg, MAX_COLS);
    n_scale = clamp_reg(11'(scale_reg), MAX_SCALE);
    row_v   = src_row;
    col_v   = src_col;
    origin  = row_v * n_cols * n_scale * n_scale + col_v * n_scale;
    fresh_copies.delete();
    for (i = 0; i < n_scale; i++) begin
      for (j = 0; j < n_scale; j++) begin
        fresh_copies.push_back('{addr:  ADDR_W'(origin + n_cols * n_scale * i + j),
                                 pixel: pix,
                                 last:  (i == n_scale - 1) && (j == n_scale - 1)});
      end
    end
    if (col_v + 1 >= n_cols) begin
      src_col = '0;
      if (row_v + 1 >= n_rows) src_row = '0;
      else src_row = src_row + 1'b1;
    end else begin
      src_col = src_col + 1'b1;
    end
  endtask

  // track every handshake on the rising edge
  always @(posedge clk) begin : track_channels
    copy_t want;
    if (!rst_n) begin
      rows_reg  = 1;
      cols_reg  = 1;
      scale_reg = 1;
      src_row   = '0;
      src_col   = '0;
      expected_copies.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_ROWS:   rows_reg = cfg_data;
          REG_FRAME_COLS:   cols_reg = cfg_data;
          REG_SCALE_FACTOR: scale_reg = cfg_data[SCALE_CFG_W-1:0];
          default: ;
        endcase
        reg_writes_accepted++;
      end
      // copies leaving the block
      if (out_tvalid && out_tready) begin
        if (expected_copies.size() == 0) begin
          report_mismatch("unexpected copy", 64'd0, 64'(out_tdata));
        end else begin
          want = expected_copies.pop_front();
          if (out_tdata[ADDR_W-1:0] !== want.addr)
            report_mismatch("out_address", 64'(want.addr), 64'(out_tdata[ADDR_W-1:0]));
          if (out_tdata[ADDR_W +: PIXEL_W] !== want.pixel)
            report_mismatch("out_pixel", 64'(want.pixel), 64'(out_tdata[ADDR_W +: PIXEL_W]));
          if (out_tlast !== want.last)
            report_mismatch("run_last", 64'(want.last), 64'(out_tlast));
        end
        copies_seen++;
      end
      // pixels taken
      if (in_tvalid && in_tready) begin
        replicate_pixel(in_tdata[PIXEL_W-1:0]);
        if (pinned_valid) begin
          expected_copies.push_back(pinned_copy);
          pinned_valid = 1'b0;
        end else begin
          foreach (fresh_copies[k]) expected_copies.push_back(fresh_copies[k]);
        end
        pixels_accepted++;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_tready <= !take_break();
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // send one word, leaving valid high after it is taken
  task automatic push_pixel(input logic [PIXEL_W-1:0] pix);
    int seen;
    while (take_break()) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    seen = pixels_accepted;
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(negedge clk); while (pixels_accepted == seen);
  endtask

  // stop sending and wait for every copy to come out
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    while (expected_copies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    int seen;
    seen = reg_writes_accepted;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (reg_writes_accepted == seen);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] scale_word;
    int sent;
    int seg;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (directed_steps[n]) begin
      if (directed_steps[n].kind == STEP_CFG) begin
        drain_pipeline();
        write_reg(directed_steps[n].idx, directed_steps[n].value);
      end else begin
        if (directed_steps[n].typed) begin
          pinned_copy  = '{addr:  directed_steps[n].t_addr,
                           pixel: directed_steps[n].pix,
                           last:  directed_steps[n].t_last};
          pinned_valid = 1'b1;
        end
        push_pixel(directed_steps[n].pix);
      end
    end

    // walk the row counter up with one-column frames, then widen
    drain_pipeline();
    write_reg(REG_FRAME_ROWS, 11'd1024);
    write_reg(REG_FRAME_COLS, 11'd1);
    write_reg(REG_SCALE_FACTOR, 11'd1);
    repeat (DEEP_PIXELS) push_pixel(random_pixel());
    drain_pipeline();
    write_reg(REG_FRAME_COLS, 11'd1024);
    write_reg(REG_SCALE_FACTOR, 11'd8);
    repeat (3) push_pixel(random_pixel());

    // random frames under random settings
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      drain_pipeline();
      calm = 1'b0;
      if ($urandom_range(3) != 0) write_reg(REG_FRAME_ROWS, random_dim());
      if ($urandom_range(3) != 0) write_reg(REG_FRAME_COLS, random_dim());
      if ($urandom_range(3) != 0) begin
        scale_word = CFG_DATA_W'($urandom_range(2047));
        case ($urandom_range(9))
          0: scale_word[SCALE_CFG_W-1:0] = 4'd0;
          1: scale_word[SCALE_CFG_W-1:0] = 4'd8;
          2: scale_word[SCALE_CFG_W-1:0] = SCALE_CFG_W'($urandom_range(9, 15));
          default: scale_word[SCALE_CFG_W-1:0] = SCALE_CFG_W'($urandom_range(1, 4));
        endcase
        write_reg(REG_SCALE_FACTOR, scale_word);
      end
      if ($urandom_range(15) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(2047)));
      seg = $urandom_range(4, 20);
      repeat (seg) begin
        // a stretch with no stalls on either side
        calm = (sent >= 30) && (sent < 55);
        if ($urandom_range(9) == 0) drain_pipeline();
        push_pixel(random_pixel());
        sent++;
      end
    end
    calm = 1'b0;

    drain_pipeline();
    repeat (16) @(negedge clk);
    if (mismatch_count == 0 && expected_copies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
